// ===== design/kms_pkg.sv =====
// Shared types and constants for the k-way merge step-sum block.
`default_nettype none

package kms_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    // Field widths
    localparam int OP_W     = 2;
    localparam int CURVE_W  = 3;
    localparam int DAY_W    = 20;
    localparam int AMOUNT_W = 32;
    localparam int TOTAL_W  = 35;
    localparam int CFG_W    = 4;
    localparam int POINT_W  = DAY_W + AMOUNT_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Saturation limits of the total
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    // Reset value of the curves-in-use register
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_SCAN = 6'b000100,
        S_FIND = 6'b001000,
        S_SUM  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== design/kms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kms_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/kway_merge_step_sum.sv =====
// Top level of the k-way merge step-sum block: sequencer, point store and shared datapath.
// Usage:
//   Input stream (s_axis): tuser carries the operation (clear, load, emit); tdata carries
//   the curve, day and amount of a point to load. Output stream (m_axis): one word per
//   emit with the merged day and saturated total in tdata, tlast set when no further
//   merged point follows, tuser set when nothing was left to emit.
//   Configuration: i_cfg_wr_en writes the number of curves taking part; write it only
//   while the block is idle.
// Sequence:
//   A clear completes in the idle state; a load does one RAM write in S_LOAD. An emit
//   over n active curves reads each curve head through the single RAM read port and
//   the shared min comparator (S_SCAN), drains the last read (S_FIND), advances curves
//   through the shared adder (S_SUM), then saturates and registers the result (S_OUT).
//   An emit that finds no pending point skips the adder pass; with no curve in use it
//   also skips the scan. o_s_axis_tready is high only while the sequencer is idle.
// Reset: i_rst_n (synchronous, active low) empties all curves, sets curves in use to 1
//   and drops any pending output word. The point RAM is not cleared; it is read only
//   below each curve's fill count.
// Back-pressure: the result sits in an output register until taken; the block keeps
//   accepting loads meanwhile, and the next emit holds in its final cycle while the
//   previous word is still waiting.
`default_nettype none

module kway_merge_step_sum #(
    parameter int MAX_CURVES       = 8,
    parameter int POINTS_PER_CURVE = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [3:0]  i_cfg_wr_data,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [55:0] i_s_axis_tdata,  // curve[2:0], day[22:3], amount[54:23], zero
    input  wire logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [55:0]      o_m_axis_tdata,  // merged_day[19:0], total[54:20], zero
    output logic             o_m_axis_tlast,
    output logic [0:0]       o_m_axis_tuser   // exhausted[0]
);

    localparam int IDX_W  = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
    localparam int NACT_W = $clog2(MAX_CURVES + 1);
    localparam int CNT_W  = $clog2(POINTS_PER_CURVE + 1);
    localparam int DEPTH  = MAX_CURVES * POINTS_PER_CURVE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = 36 + $clog2(MAX_CURVES);

    localparam int DAY_W    = kms_pkg::DAY_W;
    localparam int AMOUNT_W = kms_pkg::AMOUNT_W;
    localparam int TOTAL_W  = kms_pkg::TOTAL_W;

    // Control registers
    kms_pkg::t_state            r_state;
    logic [kms_pkg::CFG_W-1:0]  r_cfg;
    logic [CNT_W-1:0]           r_cnt [MAX_CURVES];
    logic [CNT_W-1:0]           r_pos [MAX_CURVES];
    logic                       r_rd_vld;
    logic                       r_found;
    logic                       r_out_valid;

    // Datapath registers
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_rd_idx;
    logic [DAY_W-1:0]           r_ld_day;
    logic [AMOUNT_W-1:0]        r_ld_amt;
    logic [DAY_W-1:0]           r_min;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_more;
    logic                       r_exh;
    logic [DAY_W-1:0]           r_head_day [MAX_CURVES];
    logic signed [AMOUNT_W-1:0] r_head_amt [MAX_CURVES];
    logic signed [AMOUNT_W-1:0] r_latest   [MAX_CURVES];
    logic [DAY_W-1:0]           r_o_day;
    logic signed [TOTAL_W-1:0]  r_o_total;
    logic                       r_o_last;
    logic                       r_o_exh;

    // Combinational signals
    logic                        s_acc;
    logic [1:0]                  in_op;
    logic [kms_pkg::CURVE_W-1:0] in_curve;
    logic [DAY_W-1:0]            in_day;
    logic [AMOUNT_W-1:0]         in_amt;
    logic                        in_curve_ok;
    logic [NACT_W-1:0]           n_act;
    logic                        idx_last;
    logic [CNT_W-1:0]            cur_cnt;
    logic [CNT_W-1:0]            cur_pos;
    logic                        cur_pend;
    logic [CNT_W-1:0]            addr_off;
    logic [ADDR_W-1:0]           ram_addr;
    logic                        ram_we;
    logic [kms_pkg::POINT_W-1:0] ram_wdata;
    logic [kms_pkg::POINT_W-1:0] ram_rdata;
    logic [DAY_W-1:0]            q_day;
    logic signed [AMOUNT_W-1:0]  q_amt;
    logic                        take;
    logic                        found_any;
    logic                        adv;
    logic [CNT_W-1:0]            new_pos;
    logic signed [AMOUNT_W-1:0]  latest;
    logic signed [AMOUNT_W-1:0]  contrib;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [TOTAL_W-1:0]   sat_total;
    logic                        out_free;

    // Decode the input word
    assign s_acc       = i_s_axis_tvalid && (r_state == kms_pkg::S_IDLE);
    assign in_op       = i_s_axis_tuser;
    assign in_curve    = i_s_axis_tdata[2:0];
    assign in_day      = i_s_axis_tdata[22:3];
    assign in_amt      = i_s_axis_tdata[54:23];
    assign in_curve_ok = (32'(in_curve) < MAX_CURVES);

    // Clamp the number of curves taking part
    assign n_act    = (32'(r_cfg) > MAX_CURVES) ? NACT_W'(MAX_CURVES) : NACT_W'(r_cfg);
    assign idx_last = ((NACT_W'(r_idx) + NACT_W'(1)) == n_act);

    // Per-curve view at the sequencer index
    assign cur_cnt  = r_cnt[r_idx];
    assign cur_pos  = r_pos[r_idx];
    assign cur_pend = (cur_pos < cur_cnt);

    // Point store address: curve base plus fill count on load, head position on scan
    assign addr_off  = (r_state == kms_pkg::S_LOAD) ? cur_cnt : cur_pos;
    assign ram_addr  = ADDR_W'(r_idx) * ADDR_W'(POINTS_PER_CURVE) + ADDR_W'(addr_off);
    assign ram_we    = (r_state == kms_pkg::S_LOAD) && (cur_cnt != CNT_W'(POINTS_PER_CURVE));
    assign ram_wdata = {r_ld_amt, r_ld_day};

    kms_ram #(
        .WIDTH (kms_pkg::POINT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign q_day = ram_rdata[DAY_W-1:0];
    assign q_amt = ram_rdata[kms_pkg::POINT_W-1:DAY_W];

    // Shared comparator: track the smallest pending head day
    assign take      = r_rd_vld && (!r_found || (q_day < r_min));
    assign found_any = r_found || r_rd_vld;

    // Shared adder: advance curves on the merged day and accumulate latest amounts
    assign adv      = cur_pend && (r_head_day[r_idx] == r_min);
    assign new_pos  = cur_pos + CNT_W'(adv);
    assign latest   = adv ? r_head_amt[r_idx] : r_latest[r_idx];
    assign contrib  = (new_pos != '0) ? latest : '0;
    assign acc_next = r_acc + ACC_W'(contrib);

    // Saturate the accumulated total
    always_comb begin
        if (r_acc > ACC_W'(kms_pkg::TOTAL_MAX)) begin
            sat_total = kms_pkg::TOTAL_MAX;
        end else if (r_acc < ACC_W'(kms_pkg::TOTAL_MIN)) begin
            sat_total = kms_pkg::TOTAL_MIN;
        end else begin
            sat_total = r_acc[TOTAL_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    // Sequencer and curve bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kms_pkg::S_IDLE;
            r_cfg       <= kms_pkg::CFG_RESET;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_CURVES; i++) begin
                r_cnt[i] <= '0;
                r_pos[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_rd_vld <= (r_state == kms_pkg::S_SCAN) && cur_pend;
            if ((r_state == kms_pkg::S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                kms_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_found <= 1'b0;
                        case (in_op)
                            kms_pkg::OP_CLEAR: begin
                                for (int i = 0; i < MAX_CURVES; i++) begin
                                    r_cnt[i] <= '0;
                                    r_pos[i] <= '0;
                                end
                            end
                            kms_pkg::OP_LOAD: begin
                                if (in_curve_ok) begin
                                    r_state <= kms_pkg::S_LOAD;
                                end
                            end
                            kms_pkg::OP_EMIT: begin
                                if (n_act == '0) begin
                                    r_state <= kms_pkg::S_OUT;
                                end else begin
                                    r_state <= kms_pkg::S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= kms_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
                kms_pkg::S_LOAD: begin
                    if (ram_we) begin
                        r_cnt[r_idx] <= cur_cnt + CNT_W'(1);
                    end
                    r_state <= kms_pkg::S_IDLE;
                end
                kms_pkg::S_SCAN: begin
                    r_found <= found_any;
                    if (idx_last) begin
                        r_state <= kms_pkg::S_FIND;
                    end
                end
                kms_pkg::S_FIND: begin
                    r_found <= found_any;
                    if (found_any) begin
                        r_state <= kms_pkg::S_SUM;
                    end else begin
                        r_state <= kms_pkg::S_OUT;
                    end
                end
                kms_pkg::S_SUM: begin
                    r_pos[r_idx] <= new_pos;
                    if (idx_last) begin
                        r_state <= kms_pkg::S_OUT;
                    end
                end
                kms_pkg::S_OUT: begin
                    if (out_free) begin
                        r_state <= kms_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= kms_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Datapath: index, head cache, min, accumulator and output word
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_head_day[r_rd_idx] <= q_day;
            r_head_amt[r_rd_idx] <= q_amt;
        end
        if (take) begin
            r_min <= q_day;
        end
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            case (r_state)
                kms_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_ld_day <= in_day;
                        r_ld_amt <= in_amt;
                        r_acc    <= '0;
                        r_more   <= 1'b0;
                        r_min    <= '0;
                        r_exh    <= (n_act == '0);
                        if (in_op == kms_pkg::OP_LOAD) begin
                            r_idx <= IDX_W'(in_curve);
                        end else begin
                            r_idx <= '0;
                        end
                    end
                end
                kms_pkg::S_SCAN: begin
                    r_rd_idx <= r_idx;
                    r_idx    <= idx_last ? '0 : r_idx + IDX_W'(1);
                end
                kms_pkg::S_FIND: begin
                    r_exh <= !found_any;
                end
                kms_pkg::S_SUM: begin
                    r_acc  <= acc_next;
                    r_more <= r_more || (new_pos < cur_cnt);
                    if (adv) begin
                        r_latest[r_idx] <= r_head_amt[r_idx];
                    end
                    r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
                end
                kms_pkg::S_OUT: begin
                    if (out_free) begin
                        r_o_day   <= r_min;
                        r_o_total <= sat_total;
                        r_o_last  <= !r_more;
                        r_o_exh   <= r_exh;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    // Ports
    assign o_s_axis_tready   = (r_state == kms_pkg::S_IDLE);
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {1'b0, r_o_total, r_o_day};
    assign o_m_axis_tlast    = r_o_last;
    assign o_m_axis_tuser[0] = r_o_exh;

    // A curve never consumes more points than it holds
    a_pos_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos[r_idx] <= r_cnt[r_idx])
        else $error("curve position beyond fill count");

    // The store is written only below a curve's capacity
    a_we_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(r_cnt[r_idx]) < POINTS_PER_CURVE))
        else $error("write into a full curve");

    // An exhausted word is the last one and carries a zero day and total
    a_exh_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tlast && (o_m_axis_tdata == '0)))
        else $error("exhausted word with nonzero payload");

    // An accepted emit keeps the input side busy on the next cycle
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_op == kms_pkg::OP_EMIT)) |=> !o_s_axis_tready)
        else $error("ready during emit");

endmodule

`default_nettype wire

// ===== bench/kway_merge_step_sum_tb.sv =====
// Self-checking bench for the k-way merge step-sum block: directed cases, then random merges.
module kway_merge_step_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CURVES  = 8;
    localparam int CURVE_DEPTH = 256;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [31:0] AMT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] AMT_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic [kms_pkg::DAY_W-1:0]   day;
        logic [kms_pkg::TOTAL_W-1:0] total;
        logic                        last;
        logic                        exhausted;
    } t_merged_point;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;   // curve[2:0], day[22:3], amount[54:23], zero
    logic [1:0]  i_s_axis_tuser;   // operation[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;   // merged_day[19:0], total[54:20], zero
    logic        o_m_axis_tlast;
    logic [0:0]  o_m_axis_tuser;   // exhausted[0]

    // Curve model: stored points, fill counts and merge positions per curve
    logic [kms_pkg::DAY_W-1:0]           pt_day [NUM_CURVES][CURVE_DEPTH];
    logic signed [kms_pkg::AMOUNT_W-1:0] pt_amt [NUM_CURVES][CURVE_DEPTH];
    int unsigned                fill     [NUM_CURVES] = '{default: 0};
    int unsigned                consumed [NUM_CURVES] = '{default: 0};
    logic [kms_pkg::CFG_W-1:0]  curves_cfg = kms_pkg::CFG_RESET;

    t_merged_point due_points[$];
    int  mismatches = 0;
    int  words_sent = 0;
    bit  gaps_on = 1'b1;
    int  quiet_cycles = 0;

    kway_merge_step_sum #(
        .MAX_CURVES       (NUM_CURVES),
        .POINTS_PER_CURVE (CURVE_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Curves taking part: values above the curve count act as the curve count
    function automatic int active_count();
        return (curves_cfg > NUM_CURVES) ? NUM_CURVES : int'(curves_cfg);
    endfunction

    // Smallest pending day over the active curves; 0 when nothing remains
    function automatic bit next_merge_day(output logic [kms_pkg::DAY_W-1:0] d);
        bit found = 1'b0;
        d = '0;
        for (int i = 0; i < active_count(); i++) begin
            if (consumed[i] < fill[i]) begin
                if (!found || pt_day[i][consumed[i]] < d) begin
                    d = pt_day[i][consumed[i]];
                    found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    function automatic bit points_pending();
        logic [kms_pkg::DAY_W-1:0] d;
        return next_merge_day(d);
    endfunction

    // Apply one accepted word to the curve model and queue the merged point it yields
    function automatic void track_curves(logic [1:0] op, logic [2:0] crv,
                                         logic [kms_pkg::DAY_W-1:0] dy,
                                         logic [kms_pkg::AMOUNT_W-1:0] amt);
        logic [kms_pkg::DAY_W-1:0] d;
        logic [kms_pkg::DAY_W-1:0] nd;
        longint                    sum;
        t_merged_point             p;
        case (op)
            kms_pkg::OP_CLEAR: begin
                fill     = '{default: 0};
                consumed = '{default: 0};
            end
            kms_pkg::OP_LOAD: begin
                if (fill[crv] < CURVE_DEPTH) begin
                    pt_day[crv][fill[crv]] = dy;
                    pt_amt[crv][fill[crv]] = amt;
                    fill[crv]++;
                end
            end
            kms_pkg::OP_EMIT: begin
                if (!next_merge_day(d)) begin
                    p = '{day: '0, total: '0, last: 1'b1, exhausted: 1'b1};
                end else begin
                    for (int i = 0; i < active_count(); i++)
                        if (consumed[i] < fill[i] && pt_day[i][consumed[i]] == d)
                            consumed[i]++;
                    sum = 0;
                    for (int i = 0; i < active_count(); i++)
                        if (consumed[i] > 0)
                            sum += longint'(pt_amt[i][consumed[i]-1]);
                    if (sum > longint'(kms_pkg::TOTAL_MAX))
                        sum = longint'(kms_pkg::TOTAL_MAX);
                    if (sum < longint'(kms_pkg::TOTAL_MIN))
                        sum = longint'(kms_pkg::TOTAL_MIN);
                    p.day       = d;
                    p.total     = sum[kms_pkg::TOTAL_W-1:0];
                    p.last      = !next_merge_day(nd);
                    p.exhausted = 1'b0;
                end
                due_points.push_back(p);
            end
            default: ;
        endcase
    endfunction

    // Send one word; entered and left at a falling edge, tvalid left high for the caller
    task automatic send_word(logic [1:0] op, logic [2:0] crv,
                             logic [kms_pkg::DAY_W-1:0] dy,
                             logic [kms_pkg::AMOUNT_W-1:0] amt);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, amt, dy, crv};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_curves(op, crv, dy, amt);
        if (op != OP_UNUSED)
            words_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every merged point is back and the block has settled
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (due_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_curves(logic [kms_pkg::CFG_W-1:0] v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        curves_cfg = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [kms_pkg::AMOUNT_W-1:0] pick_amount();
        case ($urandom_range(0, 7))
            0:       return AMT_MAX;
            1:       return AMT_MIN;
            default: return $urandom;
        endcase
    endfunction

    // Empty curves, ties across curves, loads after the merge started, curves in use 0 and 15
    task automatic test_directed();
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(OP_UNUSED, 3'd5, 20'hABCDE, 32'h1234_5678);
        write_curves(4'd8);
        send_word(kms_pkg::OP_LOAD, 3'd0, 20'd0, AMT_MAX);
        send_word(kms_pkg::OP_LOAD, 3'd3, 20'd0, 32'hFFFF_FFFF);
        send_word(kms_pkg::OP_LOAD, 3'd7, 20'hFFFFF, AMT_MIN);
        send_word(kms_pkg::OP_LOAD, 3'd0, 20'd5, 32'd0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        // out of order, after the merge has started
        send_word(kms_pkg::OP_LOAD, 3'd0, 20'd2, 32'd1);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(kms_pkg::OP_LOAD, 3'd1, 20'd9, 32'd7);
        write_curves(4'd0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        write_curves(4'd15);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        send_word(kms_pkg::OP_CLEAR, 3'd0, '0, '0);
        send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
    endtask

    // All eight curves at the largest, then the smallest amount
    task automatic test_total_extremes();
        write_curves(4'd8);
        send_word(kms_pkg::OP_CLEAR, 3'd7, 20'hFFFFF, AMT_MIN);
        for (int c = 0; c < NUM_CURVES; c++)
            send_word(kms_pkg::OP_LOAD, 3'(c), 20'd1, AMT_MAX);
        for (int c = 0; c < NUM_CURVES; c++)
            send_word(kms_pkg::OP_LOAD, 3'(c), 20'd2, AMT_MIN);
        repeat (3) send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
    endtask

    // Fill one curve past its depth with no idling; the extra load must be dropped
    task automatic test_full_curve();
        write_curves(4'd1);
        gaps_on = 1'b0;
        send_word(kms_pkg::OP_CLEAR, 3'd0, '0, '0);
        for (int i = 0; i <= CURVE_DEPTH; i++)
            send_word(kms_pkg::OP_LOAD, 3'd0, 20'(i * 4093), pick_amount());
        for (int i = 0; i <= CURVE_DEPTH; i++)
            send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
        gaps_on = 1'b1;
    endtask

    // One merge round: clear, interleaved ascending loads, then emits with occasional stray loads until exhausted
    task automatic run_merge_round();
        int                        left [NUM_CURVES];
        logic [kms_pkg::DAY_W-1:0] next_d [NUM_CURVES];
        int                        remaining;
        int                        c;
        remaining = 0;
        send_word(kms_pkg::OP_CLEAR, 3'($urandom), 20'($urandom), $urandom);
        for (int i = 0; i < NUM_CURVES; i++) begin
            left[i]   = $urandom_range(0, 5);
            next_d[i] = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40));
            remaining += left[i];
        end
        while (remaining > 0) begin
            c = $urandom_range(0, NUM_CURVES - 1);
            if (left[c] > 0) begin
                send_word(kms_pkg::OP_LOAD, 3'(c), next_d[c], pick_amount());
                next_d[c] = next_d[c] + 20'($urandom_range(0, 3));
                left[c]--;
                remaining--;
            end
        end
        while (points_pending()) begin
            if ($urandom_range(0, 15) == 0)
                send_word(kms_pkg::OP_LOAD, 3'($urandom), 20'($urandom_range(0, 60)),
                          pick_amount());
            send_word(kms_pkg::OP_EMIT, 3'($urandom), 20'($urandom), $urandom);
        end
        if ($urandom_range(0, 1) == 0)
            send_word(kms_pkg::OP_EMIT, 3'd0, '0, '0);
    endtask

    // Loose words of any operation and field content
    task automatic run_noise();
        repeat (8)
            send_word(2'($urandom_range(0, 3)), 3'($urandom), 20'($urandom), $urandom);
    endtask

    task automatic test_random_merges();
        logic [kms_pkg::CFG_W-1:0] phase_cfg [6];
        int                        phase_len [6];
        int                        stop_at;
        phase_cfg = '{4'd8, 4'd1, 4'($urandom_range(2, 7)), 4'd15, 4'd0, 4'd8};
        phase_len = '{150, 100, 100, 80, 30, 140};
        for (int ph = 0; ph < 6; ph++) begin
            write_curves(phase_cfg[ph]);
            stop_at = words_sent + phase_len[ph];
            while (words_sent < stop_at) begin
                if ($urandom_range(0, 9) < 8)
                    run_merge_round();
                else
                    run_noise();
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end
    endtask

    // Drive the result side ready, with random stalls while gaps are on
    always @(negedge i_clk)
        i_m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 9);

    task automatic check_field(string name, logic [kms_pkg::TOTAL_W-1:0] want,
                               logic [kms_pkg::TOTAL_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each accepted word with the oldest merged point due
    always @(posedge i_clk) begin : check_results
        t_merged_point want;
        t_merged_point got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{day: o_m_axis_tdata[19:0], total: o_m_axis_tdata[54:20],
                    last: o_m_axis_tlast, exhausted: o_m_axis_tuser[0]};
            if (due_points.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected word, expected none, actual %p", $time, got);
            end else begin
                want = due_points.pop_front();
                check_field("merged_day", 35'(want.day), 35'(got.day));
                check_field("total", want.total, got.total);
                check_field("last", 35'(want.last), 35'(got.last));
                check_field("exhausted", 35'(want.exhausted), 35'(got.exhausted));
            end
        end
    end

    // Stop the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = kms_pkg::OP_CLEAR;
        i_m_axis_tready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_total_extremes();
        test_full_curve();
        test_random_merges();
        wait_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
